// ----- hw/rtl/decimal_string_to_fixed_point_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the decimal string to fixed-point converter
// Simulation builds get concurrent checks; synthesis builds get nothing.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_STRING_TO_FIXED_POINT_MACROS_SVH
`define DECIMAL_STRING_TO_FIXED_POINT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent true implies consequent in the same cycle
`define DSTF_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent true implies consequent in the next cycle
`define DSTF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define DSTF_ASSERT_SAME(label, clk, rstn, ante, cons)
`define DSTF_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- hw/rtl/dstf_pkg.sv -----
// ----------------------------------------------------------------------------
// dstf_pkg
// Shared constants, types and the power-of-ten table for the converter.
// ----------------------------------------------------------------------------
package dstf_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_WIDTH  = 4;
    localparam int CHAR_WIDTH  = 8;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [FRAC_WIDTH-1:0]  frac_t;
    typedef logic [CHAR_WIDTH-1:0]  char_t;

    // ASCII codes of interest
    localparam char_t CHAR_DASH = 8'h2D;
    localparam char_t CHAR_DOT  = 8'h2E;
    localparam char_t CHAR_ZERO = 8'h30;
    localparam char_t CHAR_NINE = 8'h39;

    localparam frac_t FRAC_DIGITS_RESET = 4'd2;

    // Finished string handed from the parser to the scaling stage
    typedef struct packed {
        value_t base;      // digits accumulated so far
        frac_t  pad;       // powers of ten still to apply
        logic   negative;
        logic   error;
    } dstf_result_t;

    // Ten to the power k, modulo 2^32
    function automatic value_t pow10(input frac_t k);
        value_t v;
        case (k)
            4'd0:    v = 32'd1;
            4'd1:    v = 32'd10;
            4'd2:    v = 32'd100;
            4'd3:    v = 32'd1000;
            4'd4:    v = 32'd10000;
            4'd5:    v = 32'd100000;
            4'd6:    v = 32'd1000000;
            4'd7:    v = 32'd10000000;
            4'd8:    v = 32'd100000000;
            4'd9:    v = 32'd1000000000;
            4'd10:   v = 32'd1410065408;
            4'd11:   v = 32'd1215752192;
            4'd12:   v = 32'd3567587328;
            4'd13:   v = 32'd1316134912;
            4'd14:   v = 32'd276447232;
            default: v = 32'd2764472320;
        endcase
        return v;
    endfunction

    // Signed scale factor: the sign is folded into the constant
    function automatic value_t scale_factor(input logic negative, input frac_t k);
        value_t v;
        v = pow10(k);
        return negative ? (~v + value_t'(1)) : v;
    endfunction

endpackage

// ----- hw/rtl/dstf_parse.sv -----
// ----------------------------------------------------------------------------
// dstf_parse
// Character parser: keeps the per-string state and hands each finished
// string (base value, padding count, sign, error) to a result register.
// ----------------------------------------------------------------------------
`include "decimal_string_to_fixed_point_macros.svh"

module dstf_parse (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  take,          // char beat consumed this cycle
    input  dstf_pkg::char_t       char_in,
    input  logic                  last_in,
    input  dstf_pkg::frac_t       fraction_digits,
    input  logic                  res_move,      // result register emptied
    output logic                  res_valid,
    output dstf_pkg::dstf_result_t res
);
    import dstf_pkg::*;

    // Parse state
    value_t acc_reg, acc_next;
    frac_t  frac_left_reg, frac_left_next;
    logic   neg_reg, neg_next;
    logic   dot_reg, dot_next;
    logic   err_reg, err_next;
    logic   stop_reg, stop_next;
    logic   first_reg, first_next;

    // Result register
    logic         res_valid_reg, res_valid_next;
    dstf_result_t res_reg, res_next;

    // Per-character working values
    logic   active;
    logic   is_digit;
    value_t acc_step;
    value_t acc_new;
    frac_t  fl_new;
    logic   neg_new, dot_new, err_new, stop_new;

    // Decode one character against the current state
    always_comb begin
        active   = !err_reg && !stop_reg;
        is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
        acc_step = {acc_reg[VALUE_WIDTH-4:0], 3'b000}
                 + {acc_reg[VALUE_WIDTH-2:0], 1'b0}
                 + {{(VALUE_WIDTH-4){1'b0}}, char_in[3:0]};

        acc_new  = acc_reg;
        fl_new   = frac_left_reg;
        neg_new  = neg_reg;
        dot_new  = dot_reg;
        err_new  = err_reg;
        stop_new = stop_reg;

        if (active) begin
            if (is_digit) begin
                acc_new = acc_step;
                if (dot_reg) begin
                    if (frac_left_reg != '0) begin
                        fl_new = frac_left_reg - frac_t'(1);
                    end
                    if (frac_left_reg <= frac_t'(1)) begin
                        stop_new = 1'b1;
                    end
                end
            end else if (char_in == CHAR_DOT) begin
                if (dot_reg) begin
                    err_new = 1'b1;
                end else begin
                    dot_new = 1'b1;
                    fl_new  = fraction_digits;
                    if (fraction_digits == '0) begin
                        stop_new = 1'b1;
                    end
                end
            end else if (char_in == CHAR_DASH) begin
                if (!first_reg || last_in) begin
                    err_new = 1'b1;
                end else begin
                    neg_new = 1'b1;
                end
            end else begin
                err_new = 1'b1;
            end
        end
    end

    // Next state: commit on a consumed beat, clear at end of string
    always_comb begin
        acc_next       = acc_reg;
        frac_left_next = frac_left_reg;
        neg_next       = neg_reg;
        dot_next       = dot_reg;
        err_next       = err_reg;
        stop_next      = stop_reg;
        first_next     = first_reg;
        res_valid_next = res_valid_reg && !res_move;
        res_next       = res_reg;

        if (take) begin
            if (last_in) begin
                acc_next       = '0;
                frac_left_next = '0;
                neg_next       = 1'b0;
                dot_next       = 1'b0;
                err_next       = 1'b0;
                stop_next      = 1'b0;
                first_next     = 1'b1;
                res_valid_next = 1'b1;
                res_next.base     = acc_new;
                res_next.pad      = dot_new ? fl_new : fraction_digits;
                res_next.negative = neg_new;
                res_next.error    = err_new;
            end else begin
                acc_next       = acc_new;
                frac_left_next = fl_new;
                neg_next       = neg_new;
                dot_next       = dot_new;
                err_next       = err_new;
                stop_next      = stop_new;
                first_next     = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            frac_left_reg <= '0;
            neg_reg       <= 1'b0;
            dot_reg       <= 1'b0;
            err_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            first_reg     <= 1'b1;
            res_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            frac_left_reg <= frac_left_next;
            neg_reg       <= neg_next;
            dot_reg       <= dot_next;
            err_reg       <= err_next;
            stop_reg      <= stop_next;
            first_reg     <= first_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Checks
    `DSTF_ASSERT_NEXT(a_res_hold, aclk, aresetn, res_valid_reg && !res_move, res_valid_reg && $stable(res_reg))
    `DSTF_ASSERT_NEXT(a_clear_at_end, aclk, aresetn, take && last_in, first_reg && acc_reg == '0 && !err_reg)
    `DSTF_ASSERT_NEXT(a_not_first, aclk, aresetn, take && !last_in, !first_reg)
    `DSTF_ASSERT_SAME(a_stop_needs_dot, aclk, aresetn, stop_reg, dot_reg)

endmodule

// ----- hw/rtl/decimal_string_to_fixed_point.sv -----
// ----------------------------------------------------------------------------
// decimal_string_to_fixed_point
// Streams ASCII characters of a signed decimal string and returns the value
// scaled by ten to the power fraction_digits, with a parse error flag.
//
//   channel   ports                                  beat
//   s_        s_valid s_ready s_character s_last_char one character
//   m_        m_valid m_ready m_fixed_value m_parse_error one result per string
//   cfg_      cfg_valid cfg_ready cfg_data           fraction_digits write
//
// One character per cycle sustained, except that a string's last character waits
// while the parser result register holds a result that cannot move on. m_valid
// rises once the beat carrying a string's last character has passed the input
// register, the parser result register, then the output register behind one
// 32x32 multiply. Stalls on m_ propagate back through the registers; characters
// that end no string keep flowing while a result waits. cfg_ready is always high.
// Reset is synchronous, active low.
`include "decimal_string_to_fixed_point_macros.svh"

module decimal_string_to_fixed_point (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  dstf_pkg::char_t        s_character,
    input  logic                   s_last_char,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [31:0]     m_fixed_value,
    output logic                   m_parse_error,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  dstf_pkg::frac_t        cfg_data
);
    import dstf_pkg::*;

    // Configuration
    frac_t frac_digits_reg;

    // Input register
    logic  in_valid_reg, in_valid_next;
    char_t in_char_reg;
    logic  in_last_reg;

    // Output register
    logic   out_valid_reg, out_valid_next;
    value_t out_value_reg, out_value_next;
    logic   out_error_reg, out_error_next;

    // Handshake between stages
    logic         res_valid;
    dstf_result_t res;
    logic         out_free;
    logic         res_move;
    logic         res_free;
    logic         in_take;
    value_t       product;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_digits_reg <= FRAC_DIGITS_RESET;
        end else if (cfg_valid) begin
            frac_digits_reg <= cfg_data;
        end
    end

    // Stage advance logic
    assign out_free = !out_valid_reg || m_ready;
    assign res_move = res_valid && out_free;
    assign res_free = !res_valid || res_move;
    assign in_take  = in_valid_reg && (!in_last_reg || res_free);
    assign s_ready  = !in_valid_reg || in_take;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (in_take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_character;
            in_last_reg <= s_last_char;
        end
    end

    // Character parser
    dstf_parse u_parse (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .take            (in_take),
        .char_in         (in_char_reg),
        .last_in         (in_last_reg),
        .fraction_digits (frac_digits_reg),
        .res_move        (res_move),
        .res_valid       (res_valid),
        .res             (res)
    );

    // Padding and sign in one multiply by a signed power of ten
    assign product = res.base * scale_factor(res.negative, res.pad);

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_value_next = out_value_reg;
        out_error_next = out_error_reg;
        if (res_move) begin
            out_valid_next = 1'b1;
            out_value_next = res.error ? '0 : product;
            out_error_next = res.error;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_value_reg <= out_value_next;
        out_error_reg <= out_error_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_fixed_value = signed'(out_value_reg);
    assign m_parse_error = out_error_reg;

    // Checks
    `DSTF_ASSERT_NEXT(a_res_to_out, aclk, aresetn, res_move, out_valid_reg && out_error_reg == $past(res.error))
    `DSTF_ASSERT_SAME(a_error_zero, aclk, aresetn, out_valid_reg && out_error_reg, out_value_reg == '0)
    `DSTF_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_valid_reg && !m_ready, out_valid_reg && $stable(out_value_reg))

endmodule
